[hw/rtl/shab_pkg.sv]
// ----------------------------------------------------------------------------
// shab_pkg
// Shared types, constants and the rotate function for the byte-stream hasher.
// ----------------------------------------------------------------------------
package shab_pkg;

	localparam int QDepth = 4;
	localparam int QAw    = 2;

	localparam logic ActData   = 1'b0;
	localparam logic ActFinish = 1'b1;

	localparam logic [7:0] PadByte = 8'h80;
	localparam logic [5:0] LenPos  = 6'd56;

	typedef struct packed {
		logic       action;
		logic [7:0] data_byte;
	} item_t;

	typedef logic [31:0] word_t;

	localparam word_t RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam word_t InitHash [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic word_t ror(input word_t v, input int n);
		return (v >> n) | (v << (32 - n));
	endfunction

endpackage

[hw/rtl/sha256_byte_stream_hasher_unit.sv]
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher_unit
// SHA-256 over a byte stream with padding on finish and word-wise digest.
// ----------------------------------------------------------------------------
// Input side is a queue: push an item (action, data_byte) while full is low.
// action 0 appends a byte, action 1 pads the message and ends it.
// Output side is a queue: while empty is low a digest word is shown; pop
// takes it. Eight words per finish, word_index 0 first, last_word on 7.
// A four-entry input queue decouples the producer from the engine.
// Data bytes fill the block; the 64th byte of a block starts a compression
// (a load step, 64 rounds at one per cycle, an add step).
// Finish fills the rest of the block one byte per cycle, compresses once or
// twice, then writes eight words out, one per cycle unless pop stalls.
// A stalled receiver holds the engine in its output phase; the input queue
// then fills and full rises. Reset loads the initial hash values and
// clears queues, byte count and bit length.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_unit
	import shab_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        action,
	input  logic [7:0]  data_byte,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  word_index,
	output logic [31:0] digest_word,
	output logic        last_word
);

	logic  q_valid, q_take;
	item_t q_item;

	shab_front u_front (
		.clk, .arst_n, .push, .full, .action, .data_byte,
		.q_valid, .q_item, .q_take
	);

	shab_engine u_engine (
		.clk, .arst_n, .q_valid, .q_item, .q_take,
		.empty, .pop, .word_index, .digest_word, .last_word
	);

endmodule

[hw/rtl/shab_front.sv]
// ----------------------------------------------------------------------------
// shab_front
// Input queue: buffers accepted items for the compression engine.
// ----------------------------------------------------------------------------
module shab_front
	import shab_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic       action,
	input  logic [7:0] data_byte,
	output logic       q_valid,
	output item_t      q_item,
	input  logic       q_take
);

	item_t          mem_q [QDepth];
	logic [QAw-1:0] wr_q, rd_q;
	logic [QAw:0]   cnt_q;
	logic           wr_en, rd_en;

	assign full    = (cnt_q == (QAw+1)'(QDepth));
	assign q_valid = (cnt_q != '0);
	assign q_item  = mem_q[rd_q];
	assign wr_en   = push && !full;
	assign rd_en   = q_take && q_valid;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_q] <= '{action: action, data_byte: data_byte};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) wr_q <= wr_q + 1'b1;
			if (rd_en) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (QAw+1)'(wr_en) - (QAw+1)'(rd_en);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QAw+1)'(QDepth))
		else $error("queue count overflow");
	a_no_write_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |=> cnt_q == (QAw+1)'(QDepth) || $past(rd_en))
		else $error("queue count moved while full");
	a_empty_read: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == '0 |-> !rd_en)
		else $error("read from empty queue");

endmodule

[hw/rtl/shab_engine.sv]
// ----------------------------------------------------------------------------
// shab_engine
// Block collection, padding, 64-round compression and digest output.
// ----------------------------------------------------------------------------
module shab_engine
	import shab_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  item_t       q_item,
	output logic        q_take,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  word_index,
	output logic [31:0] digest_word,
	output logic        last_word
);

	typedef enum logic [5:0] {
		StIdle  = 6'b000001,
		StPad   = 6'b000010,
		StLoad  = 6'b000100,
		StRound = 6'b001000,
		StAdd   = 6'b010000,
		StOut   = 6'b100000
	} state_t;

	state_t      state_q;
	word_t       h_q [8];
	word_t       v_q [8];
	word_t       w_q [16];
	logic [5:0]  fill_q;
	logic [63:0] len_q;
	logic [5:0]  rnd_q;
	logic [5:0]  pos_q;
	logic        fin_q;
	logic        second_q;
	logic [2:0]  oidx_q;
	logic        out_v_q;
	word_t       out_w_q;
	logic        out_last_q;

	word_t       t1, t2, s0, s1, wnew, big0, big1, ch, maj;
	logic        out_free;

	assign out_free = !out_v_q || pop;
	assign q_take   = (state_q == StIdle) && q_valid;

	always_comb begin
		big1 = ror(v_q[4], 6) ^ ror(v_q[4], 11) ^ ror(v_q[4], 25);
		ch   = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1   = v_q[7] + big1 + ch + RoundK[rnd_q] + w_q[0];
		big0 = ror(v_q[0], 2) ^ ror(v_q[0], 13) ^ ror(v_q[0], 22);
		maj  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t2   = big0 + maj;
		s0   = ror(w_q[1], 7) ^ ror(w_q[1], 18) ^ (w_q[1] >> 3);
		s1   = ror(w_q[14], 17) ^ ror(w_q[14], 19) ^ (w_q[14] >> 10);
		wnew = s1 + w_q[9] + s0 + w_q[0];
	end

	// schedule words double as the block buffer, bytes big-endian per word
	always_ff @(posedge clk) begin
		if (state_q == StIdle && q_valid) begin
			if (q_item.action == ActData)
				w_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= q_item.data_byte;
			else
				w_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= PadByte;
		end else if (state_q == StPad) begin
			if (pos_q >= LenPos && second_q)
				w_q[pos_q[5:2]][{~pos_q[1:0], 3'b000} +: 8] <=
					len_q[{~pos_q[2:0], 3'b000} +: 8];
			else
				w_q[pos_q[5:2]][{~pos_q[1:0], 3'b000} +: 8] <= 8'h00;
		end else if (state_q == StRound) begin
			for (int i = 0; i < 15; i++)
				w_q[i] <= w_q[i+1];
			w_q[15] <= wnew;
		end
		if (state_q == StLoad) begin
			for (int i = 0; i < 8; i++)
				v_q[i] <= h_q[i];
		end else if (state_q == StRound) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
		if (state_q == StOut && out_free) begin
			out_w_q    <= h_q[oidx_q];
			out_last_q <= (oidx_q == 3'd7);
			word_index <= oidx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= StIdle;
			fill_q   <= '0;
			len_q    <= '0;
			rnd_q    <= '0;
			pos_q    <= '0;
			fin_q    <= 1'b0;
			second_q <= 1'b0;
			oidx_q   <= '0;
			out_v_q  <= 1'b0;
			for (int i = 0; i < 8; i++) h_q[i] <= InitHash[i];
		end else begin
			if (state_q == StOut && out_free) out_v_q <= 1'b1;
			else if (pop) out_v_q <= 1'b0;
			unique case (state_q)
				StIdle: begin
					if (q_valid) begin
						fill_q <= fill_q + 1'b1;
						if (q_item.action == ActData) begin
							len_q <= len_q + 64'd8;
							if (fill_q == 6'd63) begin
								fin_q   <= 1'b0;
								state_q <= StLoad;
							end
						end else begin
							fin_q    <= 1'b1;
							pos_q    <= fill_q + 1'b1;
							second_q <= (fill_q < LenPos);
							// pad byte filled the last slot of a block
							if (fill_q == 6'd63) state_q <= StLoad;
							else state_q <= StPad;
						end
					end
				end
				StPad: begin
					pos_q <= pos_q + 1'b1;
					if (pos_q == 6'd63) state_q <= StLoad;
				end
				StLoad: begin
					rnd_q   <= '0;
					state_q <= StRound;
				end
				StRound: begin
					rnd_q <= rnd_q + 1'b1;
					if (rnd_q == 6'd63) state_q <= StAdd;
				end
				StAdd: begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
					state_q <= StIdle;
					if (fin_q && !second_q) begin
						// length still to go: second block of zeros plus length
						second_q <= 1'b1;
						pos_q    <= '0;
						state_q  <= StPad;
					end else if (fin_q) begin
						oidx_q  <= '0;
						state_q <= StOut;
					end
				end
				StOut: begin
					if (out_free) begin
						oidx_q <= oidx_q + 1'b1;
						if (oidx_q == 3'd7) begin
							for (int i = 0; i < 8; i++) h_q[i] <= InitHash[i];
							fill_q  <= '0;
							len_q   <= '0;
							fin_q   <= 1'b0;
							state_q <= StIdle;
						end
					end
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	assign empty       = !out_v_q;
	assign digest_word = out_w_q;
	assign last_word   = out_last_q;

	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_take |-> state_q == StIdle)
		else $error("item taken while busy");
	a_round_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == StLoad |=> state_q == StRound && rnd_q == '0)
		else $error("round counter not cleared");
	a_out_only_fin: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == StOut |-> fin_q)
		else $error("digest output without finish");

endmodule

[tb/tb_sha256_byte_stream_hasher_unit.sv]
// ----------------------------------------------------------------------------
// tb_sha256_byte_stream_hasher_unit
// Self-checking bench: byte/finish items are pushed through the input queue,
// a SHA-256 predictor computes each digest and the popped words are compared.
// ----------------------------------------------------------------------------
module tb_sha256_byte_stream_hasher_unit;
	import shab_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic        action;
	logic [7:0]  data_byte;
	logic        empty;
	logic        pop;
	logic [2:0]  word_index;
	logic [31:0] digest_word;
	logic        last_word;

	typedef struct {
		logic [2:0]  idx;
		logic [31:0] word;
		logic        last;
	} digest_t;

	item_t   item_q[$];
	digest_t digest_q[$];

	// predictor state
	word_t       hv[8];
	logic [7:0]  blk[64];
	logic [5:0]  nfill;
	logic [63:0] nbits;

	int   send_idle_pct;
	int   recv_idle_pct;
	bit   recv_hold;
	bit   send_pause;
	int   hold_cycles;
	int   errors;
	int   n_items;
	int   n_words;
	int   n_msgs;
	int   stall_cnt;
	bit   done;

	int target_lens[] = '{55, 56, 63, 64};

	sha256_byte_stream_hasher_unit DUT (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.action(action), .data_byte(data_byte), .empty(empty), .pop(pop),
		.word_index(word_index), .digest_word(digest_word), .last_word(last_word)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic word_t rr(word_t v, int n);
		return (v >> n) | (v << (32 - n));
	endfunction

	task automatic compress_blk();
		word_t w[64];
		word_t v[8];
		word_t t1, t2;
		for (int i = 0; i < 16; i++)
			w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
		for (int i = 16; i < 64; i++)
			w[i] = (rr(w[i-2], 17) ^ rr(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
				+ (rr(w[i-15], 7) ^ rr(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
		v = hv;
		for (int i = 0; i < 64; i++) begin
			t1 = v[7] + (rr(v[4], 6) ^ rr(v[4], 11) ^ rr(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[i] + w[i];
			t2 = (rr(v[0], 2) ^ rr(v[0], 13) ^ rr(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			hv[i] = hv[i] + v[i];
	endtask

	task automatic predict_digest(item_t it);
		int      p;
		digest_t d;
		if (it.action == ActData) begin
			blk[nfill] = it.data_byte;
			nbits += 64'd8;
			nfill++;
			if (nfill == 6'd0)
				compress_blk();
			return;
		end
		p = nfill;
		blk[p] = PadByte;
		p++;
		if (p > LenPos) begin
			while (p < 64) begin blk[p] = 8'h00; p++; end
			compress_blk();
			p = 0;
		end
		while (p < LenPos) begin blk[p] = 8'h00; p++; end
		for (int i = 0; i < 8; i++)
			blk[LenPos + i] = nbits[8*(7-i) +: 8];
		compress_blk();
		for (int i = 0; i < 8; i++) begin
			d.idx = 3'(i);
			d.word = hv[i];
			d.last = (i == 7);
			digest_q.push_back(d);
		end
		hv = InitHash;
		nfill = '0;
		nbits = '0;
		n_msgs++;
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			action <= 1'b0;
			data_byte <= 8'h00;
		end else begin
			if (push && !full) begin
				predict_digest(item_t'{action, data_byte});
				n_items++;
			end
			if (push && full) begin
				// hold current item
			end else if (item_q.size() > 0 && !send_pause
					&& $urandom_range(99, 0) >= send_idle_pct) begin
				item_t it;
				it = item_q.pop_front();
				push <= 1'b1;
				action <= it.action;
				data_byte <= it.data_byte;
			end else begin
				push <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				n_words++;
				if (digest_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected word idx=%0d word=%h", word_index, digest_word);
				end else begin
					digest_t d;
					d = digest_q.pop_front();
					if (d.idx !== word_index || d.word !== digest_word
							|| d.last !== last_word) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: exp idx=%0d word=%h last=%b got idx=%0d word=%h last=%b",
								d.idx, d.word, d.last, word_index, digest_word, last_word);
					end
				end
			end
			pop <= !recv_hold && ($urandom_range(99, 0) >= recv_idle_pct);
		end
	end

	// watchdog on transfers
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty))
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
		if (stall_cnt > 5000 && !done) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic add_byte(logic [7:0] b);
		item_q.push_back(item_t'{ActData, b});
	endtask

	task automatic add_finish(logic [7:0] junk);
		item_q.push_back(item_t'{ActFinish, junk});
	endtask

	// message mostly short; sometimes near/over the block boundary
	task automatic add_random_msg();
		int len;
		case ($urandom_range(9, 0))
			0, 1, 2: len = $urandom_range(8, 0);
			3, 4:    len = $urandom_range(63, 50);
			5:       len = $urandom_range(130, 64);
			default: len = $urandom_range(40, 0);
		endcase
		for (int i = 0; i < len; i++)
			add_byte(8'($urandom_range(255, 0)));
		add_finish(8'($urandom_range(255, 0)));
	endtask

	task automatic wait_drain();
		while (item_q.size() > 0 || push || digest_q.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		recv_hold = 1'b0;
		send_pause = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		errors = 0; n_items = 0; n_words = 0; n_msgs = 0; done = 1'b0;
		hv = InitHash;
		nfill = '0;
		nbits = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty message, finish with data set, 0x00/0xff bytes
		add_finish(8'h00);
		add_finish(8'hff);
		add_byte(8'h00); add_byte(8'hff); add_finish(8'h5a);
		for (int i = 0; i < 3; i++) add_byte(8'("abc" >> (8 * (2 - i))));
		add_finish(8'h00);
		wait_drain();

		// boundary lengths: 55 (one block), 56 (length spills), 63, 64 (full block)
		foreach (target_lens[k]) begin
			for (int i = 0; i < target_lens[k]; i++) add_byte(8'($urandom_range(255, 0)));
			add_finish(8'h00);
		end
		wait_drain();

		// long receiver stall while the sender keeps pushing
		recv_hold = 1'b1;
		for (int m = 0; m < 3; m++) begin
			for (int i = 0; i < 10; i++) add_byte(8'($urandom_range(255, 0)));
			add_finish(8'h00);
		end
		for (hold_cycles = 0; hold_cycles < 400; hold_cycles++) @(posedge clk);
		recv_hold = 1'b0;
		wait_drain();

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 48 : 0;
			recv_idle_pct = (phase == 0) ? 48 : (phase == 1) ? 31 : 0;
			while (item_q.size() < 50)
				add_random_msg();
			while (item_q.size() > 25)
				@(posedge clk);
			// sender waits until every digest has been taken
			send_pause = 1'b1;
			while (push || digest_q.size() > 0)
				@(posedge clk);
			send_pause = 1'b0;
			wait_drain();
		end

		repeat (20) @(posedge clk);
		done = 1'b1;
		$display("items %0d, messages %0d, digest words %0d, errors %0d",
			n_items, n_msgs, n_words, errors);
		$display("covered: empty/short/boundary/multi-block messages, stalls and backpressure");
		if (errors == 0 && digest_q.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/shab_pkg.sv
hw/rtl/shab_front.sv
hw/rtl/shab_engine.sv
hw/rtl/sha256_byte_stream_hasher_unit.sv
tb/tb_sha256_byte_stream_hasher_unit.sv
